FILE: hdl/avlpf_pkg.sv
`default_nettype none
package avlpf_pkg;

	localparam int unsigned FRAME_LEN = 45;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned CFG_W     = 16;

	localparam logic [7:0] DATA_LEN_BYTE = 8'd33;
	localparam logic [7:0] CODEC_ID      = 8'h08;
	localparam logic [7:0] RECORD_COUNT  = 8'h01;
	localparam logic [15:0] CRC_POLY     = 16'hA001;

	localparam logic [1:0]  PRIO_RST = 2'd1;
	localparam logic [15:0] ALT_RST  = 16'd180;
	localparam logic [8:0]  HDG_RST  = 9'd300;
	localparam logic [7:0]  SAT_RST  = 8'd0;

	typedef enum logic [1:0] {
		REG_PRIORITY = 2'd0,
		REG_ALTITUDE = 2'd1,
		REG_HEADING  = 2'd2,
		REG_SATS     = 2'd3
	} cfg_idx_t;

	// byte source of one microcode step
	typedef enum logic [3:0] {
		SRC_CONST,
		SRC_TIME,
		SRC_PRIO,
		SRC_LON,
		SRC_LAT,
		SRC_ALT,
		SRC_HDG,
		SRC_SAT,
		SRC_SPEED,
		SRC_CRC
	} src_t;

	typedef struct packed {
		src_t       src;
		logic [2:0] sel;     // byte index from the least significant end
		logic [7:0] konst;
		logic       crc_en;
		logic       last;    // end of program: jump back to step zero
	} ucode_t;

	function automatic ucode_t mk(input src_t src, input logic [2:0] sel,
		input logic [7:0] konst, input logic crc_en, input logic last);
		ucode_t w;
		w.src    = src;
		w.sel    = sel;
		w.konst  = konst;
		w.crc_en = crc_en;
		w.last   = last;
		return w;
	endfunction

	// control store: one word per frame byte
	function automatic ucode_t ucode_rom(input logic [POS_W-1:0] step);
		ucode_t w;
		w = mk(SRC_CONST, 3'd0, 8'd0, 1'b0, 1'b0);
		unique case (step)
			6'd0, 6'd1, 6'd2, 6'd3,
			6'd4, 6'd5, 6'd6: w = mk(SRC_CONST, 3'd0, 8'd0, 1'b0, 1'b0);
			6'd7:  w = mk(SRC_CONST, 3'd0, DATA_LEN_BYTE, 1'b0, 1'b0);
			6'd8:  w = mk(SRC_CONST, 3'd0, CODEC_ID, 1'b1, 1'b0);
			6'd9:  w = mk(SRC_CONST, 3'd0, RECORD_COUNT, 1'b1, 1'b0);
			6'd10: w = mk(SRC_TIME, 3'd7, 8'd0, 1'b1, 1'b0);
			6'd11: w = mk(SRC_TIME, 3'd6, 8'd0, 1'b1, 1'b0);
			6'd12: w = mk(SRC_TIME, 3'd5, 8'd0, 1'b1, 1'b0);
			6'd13: w = mk(SRC_TIME, 3'd4, 8'd0, 1'b1, 1'b0);
			6'd14: w = mk(SRC_TIME, 3'd3, 8'd0, 1'b1, 1'b0);
			6'd15: w = mk(SRC_TIME, 3'd2, 8'd0, 1'b1, 1'b0);
			6'd16: w = mk(SRC_TIME, 3'd1, 8'd0, 1'b1, 1'b0);
			6'd17: w = mk(SRC_TIME, 3'd0, 8'd0, 1'b1, 1'b0);
			6'd18: w = mk(SRC_PRIO, 3'd0, 8'd0, 1'b1, 1'b0);
			6'd19: w = mk(SRC_LON, 3'd3, 8'd0, 1'b1, 1'b0);
			6'd20: w = mk(SRC_LON, 3'd2, 8'd0, 1'b1, 1'b0);
			6'd21: w = mk(SRC_LON, 3'd1, 8'd0, 1'b1, 1'b0);
			6'd22: w = mk(SRC_LON, 3'd0, 8'd0, 1'b1, 1'b0);
			6'd23: w = mk(SRC_LAT, 3'd3, 8'd0, 1'b1, 1'b0);
			6'd24: w = mk(SRC_LAT, 3'd2, 8'd0, 1'b1, 1'b0);
			6'd25: w = mk(SRC_LAT, 3'd1, 8'd0, 1'b1, 1'b0);
			6'd26: w = mk(SRC_LAT, 3'd0, 8'd0, 1'b1, 1'b0);
			6'd27: w = mk(SRC_ALT, 3'd1, 8'd0, 1'b1, 1'b0);
			6'd28: w = mk(SRC_ALT, 3'd0, 8'd0, 1'b1, 1'b0);
			6'd29: w = mk(SRC_HDG, 3'd1, 8'd0, 1'b1, 1'b0);
			6'd30: w = mk(SRC_HDG, 3'd0, 8'd0, 1'b1, 1'b0);
			6'd31: w = mk(SRC_SAT, 3'd0, 8'd0, 1'b1, 1'b0);
			6'd32: w = mk(SRC_SPEED, 3'd1, 8'd0, 1'b1, 1'b0);
			6'd33: w = mk(SRC_SPEED, 3'd0, 8'd0, 1'b1, 1'b0);
			6'd34, 6'd35, 6'd36,
			6'd37, 6'd38, 6'd39: w = mk(SRC_CONST, 3'd0, 8'd0, 1'b1, 1'b0);
			6'd40: w = mk(SRC_CONST, 3'd0, RECORD_COUNT, 1'b1, 1'b0);
			6'd41, 6'd42: w = mk(SRC_CONST, 3'd0, 8'd0, 1'b0, 1'b0);
			6'd43: w = mk(SRC_CRC, 3'd1, 8'd0, 1'b0, 1'b0);
			6'd44: w = mk(SRC_CRC, 3'd0, 8'd0, 1'b0, 1'b1);
			default: w = mk(SRC_CONST, 3'd0, 8'd0, 1'b0, 1'b1);
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/avlpf_ifs.sv
`default_nettype none
interface avlpf_rec_if;
	logic               valid;
	logic               ready;
	logic [62:0]        timestamp_ms;
	logic signed [31:0] longitude_e7;
	logic signed [30:0] latitude_e7;
	logic [15:0]        ground_speed;

	modport source (output valid, output timestamp_ms, output longitude_e7,
		output latitude_e7, output ground_speed, input ready);
	modport sink (input valid, input timestamp_ms, input longitude_e7,
		input latitude_e7, input ground_speed, output ready);
endinterface

interface avlpf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic [5:0] byte_position;
	logic       last_byte;

	modport source (output valid, output frame_byte, output byte_position,
		output last_byte, input ready);
	modport sink (input valid, input frame_byte, input byte_position,
		input last_byte, output ready);
endinterface
`default_nettype wire

FILE: hdl/avlpf_crc16.sv
`default_nettype none
module avlpf_crc16 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        clear,
	input  wire logic        enable,
	input  wire logic [7:0]  data,
	output      logic [15:0] crc
);
	import avlpf_pkg::*;

	logic [15:0] crc_q;
	logic [15:0] crc_next;

	// reflected crc, one byte folded in per cycle while enable is high
	always_comb begin
		crc_next = crc_q ^ {8'd0, data};
		for (int k = 0; k < 8; k++) begin
			if (crc_next[0]) begin
				crc_next = (crc_next >> 1) ^ CRC_POLY;
			end else begin
				crc_next = crc_next >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (clear) begin
			crc_q <= '0;
		end else if (enable) begin
			crc_q <= crc_next;
		end
	end

	assign crc = crc_q;
endmodule
`default_nettype wire

FILE: hdl/avl_record_packet_framer_unit.sv
// avl record packet framer
// rec_in takes one position record per transfer (timestamp, longitude,
// latitude, speed); byte_out gives the 45-byte codec-8 frame one byte per
// transfer, each with its offset and a flag on the final crc byte.
// cfg_we/cfg_index/cfg_data write priority, altitude, heading and satellite
// count; they are sampled as the bytes go out, so write them only while idle.
// a record is taken when the block is idle, or in the same cycle as the last
// byte of the previous frame enters the output register. once a record is
// taken, the bytes follow one per cycle while byte_out is not stalled, so
// frames from back-to-back records follow each other without a gap. the byte
// rate is set by the microcode step counter, which issues one control word,
// hence one byte, per cycle into a single output register unless byte_out stalls.
// the crc-16 is accumulated over bytes 8 to 40 as they are issued.
// a stall on byte_out holds the output register and freezes the step counter;
// nothing is lost or repeated. reset clears the sequencer, the output valid
// and the crc, and loads the registers with their defaults; there is no
// clearing pass.
`default_nettype none
module avl_record_packet_framer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire avlpf_pkg::cfg_idx_t         cfg_index,
	input  wire logic [avlpf_pkg::CFG_W-1:0] cfg_data,
	avlpf_rec_if.sink                        rec_in,
	avlpf_byte_if.source                     byte_out
);
	import avlpf_pkg::*;

	// configuration registers
	logic [1:0]  prio_q;
	logic [15:0] alt_q;
	logic [8:0]  hdg_q;
	logic [7:0]  sat_q;

	// held record
	logic [62:0] ts_q;
	logic [31:0] lon_q;
	logic [31:0] lat_q;
	logic [15:0] speed_q;

	// sequencer
	logic             busy_q;
	logic [POS_W-1:0] step_q;
	ucode_t           uc;
	logic             issue;
	logic             accept;

	// datapath
	logic [63:0] src_word;
	logic [7:0]  byte_sel;
	logic [15:0] crc;

	// output register
	logic             ov_q;
	logic [7:0]       byte_q;
	logic [POS_W-1:0] pos_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_q <= PRIO_RST;
			alt_q  <= ALT_RST;
			hdg_q  <= HDG_RST;
			sat_q  <= SAT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRIORITY: prio_q <= cfg_data[1:0];
				REG_ALTITUDE: alt_q  <= cfg_data[15:0];
				REG_HEADING:  hdg_q  <= cfg_data[8:0];
				REG_SATS:     sat_q  <= cfg_data[7:0];
				default:      prio_q <= prio_q;
			endcase
		end
	end

	// control word of the current step
	assign uc     = ucode_rom(step_q);
	// a step issues whenever the output register is free or being drained
	assign issue  = busy_q && (!ov_q || byte_out.ready);
	// the next record may enter as the final step issues
	assign rec_in.ready = !busy_q || (issue && uc.last);
	assign accept = rec_in.valid && rec_in.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			ts_q    <= rec_in.timestamp_ms;
			lon_q   <= rec_in.longitude_e7;
			lat_q   <= {rec_in.latitude_e7[30], rec_in.latitude_e7};
			speed_q <= rec_in.ground_speed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (issue) begin
			if (uc.last) begin
				// end of program: jump to step zero and wait for a record
				busy_q <= 1'b0;
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// byte source selection
	always_comb begin
		case (uc.src)
			SRC_TIME:  src_word = {1'b0, ts_q};
			SRC_PRIO:  src_word = {62'd0, prio_q};
			SRC_LON:   src_word = {32'd0, lon_q};
			SRC_LAT:   src_word = {32'd0, lat_q};
			SRC_ALT:   src_word = {48'd0, alt_q};
			SRC_HDG:   src_word = {55'd0, hdg_q};
			SRC_SAT:   src_word = {56'd0, sat_q};
			SRC_SPEED: src_word = {48'd0, speed_q};
			SRC_CRC:   src_word = {48'd0, crc};
			default:   src_word = {56'd0, uc.konst};
		endcase
	end

	assign byte_sel = src_word[{uc.sel, 3'b000} +: 8];

	avlpf_crc16 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (accept),
		.enable (issue && uc.crc_en),
		.data   (byte_sel),
		.crc    (crc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (issue) begin
			ov_q <= 1'b1;
		end else if (byte_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			byte_q <= byte_sel;
			pos_q  <= step_q;
			last_q <= uc.last;
		end
	end

	assign byte_out.valid         = ov_q;
	assign byte_out.frame_byte    = byte_q;
	assign byte_out.byte_position = pos_q;
	assign byte_out.last_byte     = last_q;

	// last flag only on the final frame offset
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && last_q |-> pos_q == POS_W'(FRAME_LEN - 1))
		else $error("last byte flag away from final offset");

	// crc only folds in data bytes
	a_crc_window: assert property (@(posedge clk) disable iff (!arst_n)
		issue && uc.crc_en |-> step_q >= POS_W'(8) && step_q <= POS_W'(40))
		else $error("crc update outside data bytes");

	// an accepted record starts the program at step zero
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && step_q == '0)
		else $error("record transfer did not start the sequencer");

	// idle sequencer rests at step zero
	a_idle_step: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> step_q == '0)
		else $error("step counter moved while idle");

endmodule
`default_nettype wire
